/* sv/ofsc_pkg.sv */
// Shared types and constants for the 1-Wire slave function-command engine.
package ofsc_pkg;

	localparam int TEMP_SCRATCH_LEN = 9;
	localparam int MEM_SCRATCH_LEN  = 13;
	localparam int MEM_BYTES        = 16;
	localparam int COPY_LEN         = 3;

	// One memory holds all three stores, one 16-entry region each.
	localparam int REGION_BITS = 4;
	localparam int MEM_DEPTH   = 3 * (1 << REGION_BITS);
	localparam int MEM_AW      = 6;

	localparam logic [1:0] REGION_TEMP = 2'd0;
	localparam logic [1:0] REGION_MSCR = 2'd1;
	localparam logic [1:0] REGION_DATA = 2'd2;

	localparam logic [2:0] ACT_WRITE     = 3'd0;
	localparam logic [2:0] ACT_READ      = 3'd1;
	localparam logic [2:0] ACT_BUS_RESET = 3'd2;
	localparam logic [2:0] ACT_LOAD_TEMP = 3'd3;
	localparam logic [2:0] ACT_SET_VALID = 3'd4;
	localparam logic [2:0] ACT_LOAD_MEM  = 3'd5;

	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_MSCR    = 8'hAA;
	localparam logic [7:0] CMD_READ_MEM     = 8'hF0;
	localparam logic [7:0] CMD_WRITE_MSCR   = 8'h0F;
	localparam logic [7:0] CMD_COPY_MSCR    = 8'h55;

	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic [3:0] load_index;
		logic       byte_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       slave_drives;
		logic       conversion_request;
		logic       scratch_valid;
	} out_item_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic vld;
		logic drives;
		logic conv_req;
		logic scr_valid;
	} s1_meta_t;

endpackage

/* sv/ofsc_mem.sv */
// Byte store for temperature scratchpad, memory scratchpad and memory data.
module ofsc_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  ofsc_pkg::mem_req_t req,
	output logic [7:0]      rd_data
);
	import ofsc_pkg::*;

	logic [7:0]           mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [7:0]           rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 8'd0;

endmodule

/* sv/ofsc_ctrl.sv */
// Command sequencer: decodes each beat, issues the store access, tracks flags.
module ofsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  ofsc_pkg::in_item_t item,
	output ofsc_pkg::mem_req_t req,
	output ofsc_pkg::s1_meta_t meta_s1
);
	import ofsc_pkg::*;

	typedef enum logic [3:0] {
		PH_WAIT_RESET,
		PH_CMD,
		PH_TEMP_READ,
		PH_MSCR_READ,
		PH_RD_ADDR_LO,
		PH_RD_ADDR_HI,
		PH_RD_STREAM,
		PH_WR_ADDR_LO,
		PH_WR_ADDR_HI,
		PH_WR_DATA,
		PH_COPY
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] idx_q, idx_d;
	logic [3:0] addr_q, addr_d;
	logic       valid_q, valid_d;
	logic       creq_q, creq_d;
	logic       drives;
	logic [4:0] idx_inc;

	assign idx_inc = {1'b0, idx_q} + 5'd1;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		addr_d    = addr_q;
		valid_d   = valid_q;
		creq_d    = creq_q;
		drives    = 1'b0;
		req.rd    = 1'b0;
		req.wr    = 1'b0;
		req.addr  = '0;
		req.wdata = item.byte_value;
		unique case (item.action)
			ACT_WRITE: begin
				if (item.byte_error) begin
					phase_d = PH_WAIT_RESET;
				end else begin
					unique case (phase_q)
						PH_CMD: begin
							idx_d = '0;
							unique case (item.byte_value)
								CMD_READ_SCRATCH: phase_d = valid_q ? PH_TEMP_READ : PH_WAIT_RESET;
								CMD_CONVERT: begin
									valid_d = 1'b0;
									creq_d  = 1'b1;
									phase_d = PH_WAIT_RESET;
								end
								CMD_READ_MSCR:  phase_d = PH_MSCR_READ;
								CMD_READ_MEM:   phase_d = PH_RD_ADDR_LO;
								CMD_WRITE_MSCR: phase_d = PH_WR_ADDR_LO;
								CMD_COPY_MSCR:  phase_d = PH_COPY;
								default:        phase_d = PH_WAIT_RESET;
							endcase
						end
						PH_RD_ADDR_LO: begin
							addr_d  = item.byte_value[3:0];
							phase_d = PH_RD_ADDR_HI;
						end
						PH_RD_ADDR_HI: phase_d = PH_RD_STREAM;
						PH_WR_ADDR_LO: phase_d = PH_WR_ADDR_HI;
						PH_WR_ADDR_HI: begin
							idx_d   = '0;
							phase_d = PH_WR_DATA;
						end
						PH_WR_DATA: begin
							req.wr   = 1'b1;
							req.addr = {REGION_MSCR, idx_q};
							idx_d    = idx_inc[3:0];
							if (idx_inc >= 5'(MEM_SCRATCH_LEN)) begin
								phase_d = PH_WAIT_RESET;
							end
						end
						PH_COPY: begin
							idx_d = idx_inc[3:0];
							if (idx_inc >= 5'(COPY_LEN)) begin
								phase_d = PH_WAIT_RESET;
							end
						end
						PH_TEMP_READ, PH_MSCR_READ, PH_RD_STREAM: phase_d = PH_WAIT_RESET;
						default: ;
					endcase
				end
			end
			ACT_READ: begin
				unique case (phase_q)
					PH_TEMP_READ: begin
						drives   = 1'b1;
						req.rd   = 1'b1;
						req.addr = {REGION_TEMP, idx_q};
						idx_d    = idx_inc[3:0];
						if (idx_inc >= 5'(TEMP_SCRATCH_LEN)) begin
							phase_d = PH_WAIT_RESET;
						end
					end
					PH_MSCR_READ: begin
						drives   = 1'b1;
						req.rd   = 1'b1;
						req.addr = {REGION_MSCR, idx_q};
						idx_d    = idx_inc[3:0];
						if (idx_inc >= 5'(MEM_SCRATCH_LEN)) begin
							phase_d = PH_WAIT_RESET;
						end
					end
					PH_RD_STREAM: begin
						drives   = 1'b1;
						req.rd   = 1'b1;
						req.addr = {REGION_DATA, addr_q};
						addr_d   = addr_q + 4'd1;
					end
					default: ;
				endcase
			end
			ACT_BUS_RESET: begin
				phase_d = PH_CMD;
				idx_d   = '0;
			end
			ACT_LOAD_TEMP: begin
				if ({1'b0, item.load_index} < 5'(TEMP_SCRATCH_LEN)) begin
					req.wr   = 1'b1;
					req.addr = {REGION_TEMP, item.load_index};
				end
			end
			ACT_SET_VALID: begin
				valid_d = 1'b1;
				creq_d  = 1'b0;
			end
			ACT_LOAD_MEM: begin
				req.wr   = 1'b1;
				req.addr = {REGION_DATA, item.load_index};
			end
			default: ;
		endcase
		// drop the access unless the beat is taken
		if (!acc) begin
			req.rd = 1'b0;
			req.wr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_RESET;
			idx_q   <= '0;
			addr_q  <= '0;
			valid_q <= 1'b0;
			creq_q  <= 1'b0;
			meta_s1 <= '0;
		end else begin
			meta_s1.vld <= acc;
			if (acc) begin
				phase_q           <= phase_d;
				idx_q             <= idx_d;
				addr_q            <= addr_d;
				valid_q           <= valid_d;
				creq_q            <= creq_d;
				meta_s1.drives    <= drives;
				meta_s1.conv_req  <= creq_d;
				meta_s1.scr_valid <= valid_d;
			end
		end
	end

endmodule

/* sv/ofsc_oq.sv */
// Four-entry result queue between the store read and the output channel.
module ofsc_oq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ofsc_pkg::out_item_t push_data,
	output logic                result_valid,
	input  logic                result_stall,
	output ofsc_pkg::out_item_t result,
	output logic [2:0]          count
);
	import ofsc_pkg::*;

	out_item_t  buf_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != 3'd0);
	assign result       = buf_q[rptr_q];
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			count_q <= count_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

/* sv/onewire_slave_function_commands.sv */
// Top level of the 1-Wire slave function-command engine.
//
//   channel | direction | handshake                   | payload
//   item    | in        | item_valid / item_stall     | in_item_t
//   result  | out       | result_valid / result_stall | out_item_t
//
// One beat per cycle while item_stall is low: a beat taken at an edge reads or writes
// the byte store at that edge; its result enters the output queue at the next edge.
// result_valid rises once that result is in the queue; the result beat is taken
// while result_valid is high and result_stall is low.
// item_stall rises when the in-flight beat plus the queued results reach four.
// Reset clears the command phase, flags and the store's per-entry valid bits.
module onewire_slave_function_commands (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  ofsc_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output ofsc_pkg::out_item_t result
);
	import ofsc_pkg::*;

	logic      acc;
	mem_req_t  req;
	s1_meta_t  meta_s1;
	logic [7:0] rd_data;
	out_item_t push_data;
	logic [2:0] count;
	logic [2:0] in_flight;

	assign in_flight  = count + {2'b0, meta_s1.vld};
	assign item_stall = (in_flight >= 3'd4);
	assign acc        = item_valid && !item_stall;

	ofsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.item    (item),
		.req     (req),
		.meta_s1 (meta_s1)
	);

	ofsc_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	always_comb begin
		push_data.read_byte          = meta_s1.drives ? rd_data : IDLE_BYTE;
		push_data.slave_drives       = meta_s1.drives;
		push_data.conversion_request = meta_s1.conv_req;
		push_data.scratch_valid      = meta_s1.scr_valid;
	end

	ofsc_oq u_oq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (meta_s1.vld),
		.push_data    (push_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.count        (count)
	);

endmodule
